// ----- sv/stl_pkg.sv -----
// shared types, constants and byte classifiers for the source text lexer
`default_nettype none

package stl_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int LINE_BITS_DEF     = 16;

  localparam int START_W    = 24;
  localparam int LENGTH_W   = 24;
  localparam int LINE_W     = 16;
  localparam int PREFIX_W   = 40;
  localparam int MAX_TOKENS = 3;
  localparam int COUNT_W    = $clog2(MAX_TOKENS + 1);
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_STRING  = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_IDENT   = 3'd2,
    KIND_SYMBOL  = 3'd3,
    KIND_UNKNOWN = 3'd4,
    KIND_END     = 3'd5
  } token_kind_e;

  typedef enum logic [1:0] {
    KW_VAR   = 2'd0,
    KW_FUNC  = 2'd1,
    KW_PRINT = 2'd2,
    KW_NONE  = 2'd3
  } keyword_id_e;

  localparam logic [PREFIX_W-1:0] TEXT_VAR   = 40'h00_0076_6172;
  localparam logic [PREFIX_W-1:0] TEXT_FUNC  = 40'h00_6675_6E63;
  localparam logic [PREFIX_W-1:0] TEXT_PRINT = 40'h70_7269_6E74;

  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          token_kind;
    logic [1:0]          keyword_id;
    logic [START_W-1:0]  token_start;
    logic [LENGTH_W-1:0] token_length;
    logic [LINE_W-1:0]   line_number;
    logic                is_last;
  } out_item_t;

  // all tokens caused by one input item
  typedef struct packed {
    logic [COUNT_W-1:0]             count;
    out_item_t [MAX_TOKENS-1:0]     tok;
  } tok_bundle_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == CH_UNDERSCORE;
  endfunction

  function automatic logic is_ident_char(input logic [7:0] b);
    return is_alpha(b) || (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_symbol(input logic [7:0] b);
    return b == 8'h3D || b == 8'h2B || b == 8'h28 || b == 8'h29 ||
           b == 8'h7B || b == 8'h7D || b == 8'h2C;
  endfunction

endpackage

`default_nettype wire

// ----- sv/stl_front.sv -----
// front end: scans one source byte per cycle when not stalled, builds the tokens it closes
`default_nettype none

module stl_front
  import stl_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LINE_BITS     = LINE_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  in_item_t    in_item_i,
  output logic        in_stall_o,
  input  wire         full_i,
  output logic        push_o,
  output tok_bundle_t bundle_o
);

  localparam int PB = POSITION_BITS;
  localparam int LB = LINE_BITS;
  localparam int SW = (PB > START_W) ? PB : START_W;
  localparam int LW = (LB > LINE_W) ? LB : LINE_W;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_COMMENT = 3'd5
  } scan_mode_e;

  scan_mode_e          mode_q, mode_d;
  logic [PB-1:0]       pos_q, pos_d;
  logic [LB-1:0]       line_q, line_d;
  logic [PB-1:0]       start_q, start_d;
  logic [PB-1:0]       len_q, len_d;
  logic [PREFIX_W-1:0] prefix_q, prefix_d;

  logic [COUNT_W-1:0]         n_v;
  out_item_t [MAX_TOKENS-1:0] toks_v;
  logic                       do_idle;
  logic [7:0]                 b;
  logic                       accept;

  function automatic logic [PB-1:0] pos_inc(input logic [PB-1:0] x);
    return (x == {PB{1'b1}}) ? x : x + PB'(1);
  endfunction

  function automatic out_item_t make_tok(input logic [2:0] kind, input logic [1:0] kw,
                                         input logic [PB-1:0] start, input logic [PB-1:0] len,
                                         input logic [LB-1:0] line, input logic last);
    out_item_t   t;
    logic [SW-1:0] s_w;
    logic [SW-1:0] l_w;
    logic [LW-1:0] n_w;
    s_w = SW'(start);
    l_w = SW'(len);
    n_w = LW'(line);
    t.token_kind   = kind;
    t.keyword_id   = kw;
    t.token_start  = s_w[START_W-1:0];
    t.token_length = l_w[LENGTH_W-1:0];
    t.line_number  = n_w[LINE_W-1:0];
    t.is_last      = last;
    return t;
  endfunction

  function automatic out_item_t ident_tok(input logic [PB-1:0] start, input logic [PB-1:0] len,
                                          input logic [PREFIX_W-1:0] prefix,
                                          input logic [LB-1:0] line);
    keyword_id_e kw;
    kw = KW_NONE;
    if (len == PB'(3) && prefix == TEXT_VAR) begin
      kw = KW_VAR;
    end else if (len == PB'(4) && prefix == TEXT_FUNC) begin
      kw = KW_FUNC;
    end else if (len == PB'(5) && prefix == TEXT_PRINT) begin
      kw = KW_PRINT;
    end
    return make_tok((kw == KW_NONE) ? KIND_IDENT : KIND_KEYWORD, kw, start, len, line, 1'b0);
  endfunction

  assign b          = in_item_i.source_byte;
  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    line_d   = line_q;
    start_d  = start_q;
    len_d    = len_q;
    prefix_d = prefix_q;
    n_v      = '0;
    toks_v   = '0;
    do_idle  = 1'b0;

    if (in_item_i.has_byte) begin
      case (mode_q)
        MODE_IDENT: begin
          if (is_ident_char(b)) begin
            if (len_q < PB'(5)) begin
              prefix_d = {prefix_q[PREFIX_W-9:0], b};
            end
            len_d = pos_inc(len_q);
          end else begin
            toks_v[n_v] = ident_tok(start_q, len_q, prefix_q, line_q);
            n_v = n_v + COUNT_W'(1);
            do_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            toks_v[n_v] = make_tok(KIND_STRING, KW_NONE, start_q, len_q, line_q, 1'b0);
            n_v = n_v + COUNT_W'(1);
            mode_d = MODE_IDLE;
          end else begin
            if (b == CH_BACKSLASH) begin
              mode_d = MODE_ESCAPE;
            end
            len_d = pos_inc(len_q);
          end
        end
        MODE_ESCAPE: begin
          len_d  = pos_inc(len_q);
          mode_d = MODE_STRING;
        end
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            mode_d = MODE_COMMENT;
          end else begin
            toks_v[n_v] = make_tok(KIND_UNKNOWN, KW_NONE, start_q, PB'(1), line_q, 1'b0);
            n_v = n_v + COUNT_W'(1);
            do_idle = 1'b1;
          end
        end
        MODE_COMMENT: begin
          do_idle = (b == CH_NEWLINE);
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // byte seen with no token open
      if (do_idle) begin
        mode_d = MODE_IDLE;
        if (b == CH_NEWLINE) begin
          if (line_q != {LB{1'b1}}) begin
            line_d = line_q + LB'(1);
          end
        end else if (is_space(b)) begin
          mode_d = MODE_IDLE;
        end else if (b == CH_SLASH) begin
          mode_d  = MODE_SLASH;
          start_d = pos_q;
        end else if (b == CH_QUOTE) begin
          mode_d  = MODE_STRING;
          start_d = pos_inc(pos_q);
          len_d   = '0;
        end else if (is_alpha(b)) begin
          mode_d   = MODE_IDENT;
          start_d  = pos_q;
          len_d    = PB'(1);
          prefix_d = PREFIX_W'(b);
        end else if (is_symbol(b)) begin
          toks_v[n_v] = make_tok(KIND_SYMBOL, KW_NONE, pos_q, PB'(1), line_q, 1'b0);
          n_v = n_v + COUNT_W'(1);
        end else begin
          toks_v[n_v] = make_tok(KIND_UNKNOWN, KW_NONE, pos_q, PB'(1), line_q, 1'b0);
          n_v = n_v + COUNT_W'(1);
        end
      end
      pos_d = pos_inc(pos_q);
    end

    if (in_item_i.end_of_source) begin
      case (mode_d)
        MODE_IDENT: begin
          toks_v[n_v] = ident_tok(start_d, len_d, prefix_d, line_d);
          n_v = n_v + COUNT_W'(1);
        end
        MODE_STRING, MODE_ESCAPE: begin
          toks_v[n_v] = make_tok(KIND_STRING, KW_NONE, start_d, len_d, line_d, 1'b0);
          n_v = n_v + COUNT_W'(1);
        end
        MODE_SLASH: begin
          toks_v[n_v] = make_tok(KIND_UNKNOWN, KW_NONE, start_d, PB'(1), line_d, 1'b0);
          n_v = n_v + COUNT_W'(1);
        end
        default: begin
          n_v = n_v;
        end
      endcase
      toks_v[n_v] = make_tok(KIND_END, KW_NONE, pos_d, '0, line_d, 1'b1);
      n_v = n_v + COUNT_W'(1);
      // start over for the next source
      mode_d   = MODE_IDLE;
      pos_d    = '0;
      line_d   = LB'(1);
      start_d  = '0;
      len_d    = '0;
      prefix_d = '0;
    end
  end

  assign push_o         = accept && (n_v != '0);
  assign bundle_o.count = n_v;
  assign bundle_o.tok   = toks_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      line_q   <= LB'(1);
      start_q  <= '0;
      len_q    <= '0;
      prefix_q <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      start_q  <= start_d;
      len_q    <= len_d;
      prefix_q <= prefix_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/stl_queue.sv -----
// short queue of token bundles between the scanner and the output side
`default_nettype none

module stl_queue
  import stl_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push_i,
  input  tok_bundle_t push_data_i,
  input  wire         pop_i,
  output logic        valid_o,
  output tok_bundle_t data_o,
  output logic        full_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tok_bundle_t    mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= ptr_next(wr_q);
      end
      if (do_pop) begin
        rd_q <= ptr_next(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/stl_back.sv -----
// back end: hands out each bundle's tokens one per cycle, unless stalled, through an output register
`default_nettype none

module stl_back
  import stl_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         q_valid_i,
  input  tok_bundle_t q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  output out_item_t   out_item_o,
  input  wire         out_stall_i
);

  tok_bundle_t        bun_q;
  logic               bun_valid_q;
  logic [COUNT_W-1:0] idx_q;
  out_item_t          out_q;
  logic               out_valid_q;

  logic adv;
  logic last_tok;
  logic bun_free;

  assign adv      = bun_valid_q && (!out_valid_q || !out_stall_i);
  assign last_tok = (idx_q == bun_q.count - COUNT_W'(1));
  assign bun_free = !bun_valid_q || (adv && last_tok);
  assign q_pop_o  = bun_free && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bun_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        bun_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (adv) begin
        idx_q <= idx_q + COUNT_W'(1);
        if (last_tok) begin
          bun_valid_q <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      bun_q <= q_data_i;
    end
    if (adv) begin
      out_q <= bun_q.tok[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/source_text_lexer_unit.sv -----
// lexer top level: scanner front end, bundle queue, token output back end
// path: tokens pass through a queue entry, the bundle register and output register
// throughput: one item per cycle while each item yields at most one token and the
// output is not stalled; the output side gives one token per cycle, so items
// yielding 2 or 3 tokens hold the output longer, buffered by a 2-entry bundle queue
// reset: scanner idle, offset 0, line 1, queue and output register empty
`default_nettype none

module source_text_lexer_unit
  import stl_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LINE_BITS     = LINE_BITS_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  wire       out_stall_i
);

  logic        push;
  tok_bundle_t push_data;
  logic        full;
  logic        q_valid;
  tok_bundle_t q_data;
  logic        q_pop;

  stl_front #(
    .POSITION_BITS (POSITION_BITS),
    .LINE_BITS     (LINE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  stl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .full_o      (full)
  );

  stl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire
